FILE: hdl/ffha_pkg.sv
package ffha_pkg;

  localparam int unsigned GRANULE_BYTES_DEF = 16;
  localparam int unsigned HEADER_BYTES_DEF  = 16;
  localparam int unsigned MAX_BLOCKS_DEF    = 256;
  localparam int unsigned HEAP_BYTES_DEF    = 65536;

  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 16;
  localparam int RSIZE_W  = 17;
  localparam int STATUS_W = 2;

  // reciprocal scale for rounding up to the granule
  localparam int RECIP_SHIFT = 30;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_NOMEM   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    RES_ZERO  = 2'd0,
    RES_START = 2'd1,
    RES_TOP   = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     round_q;
    logic     round_r;
    logic     scan_clr;
    logic     scan_step;
    logic     reuse_wr;
    logic     release_wr;
    logic     append;
    logic     cut;
    logic     res_set;
    res_sel_t res_sel;
    status_t  res_status;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic size_zero;
    logic addr_null;
    logic count_zero;
    logic scan_end;
    logic fit;
    logic addr_hit;
    logic blk_free;
    logic nomem;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: hdl/ffha_ctrl.sv
module ffha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ffha_pkg::dp_sts_t sts,
  output ffha_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ROUND_R,
    S_ALLOC_SCAN,
    S_APPEND,
    S_FREE_SCAN,
    S_TAIL_SCAN,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.op == ffha_pkg::OP_ALLOC) begin
          if (sts.size_zero) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ffha_pkg::ST_IGNORED;
            state_nxt      = S_EMIT;
          end else begin
            cmd.round_q = 1'b1;
            state_nxt   = S_ROUND_R;
          end
        end else begin
          if (sts.addr_null || sts.count_zero) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ffha_pkg::ST_IGNORED;
            state_nxt      = S_EMIT;
          end else begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_FREE_SCAN;
          end
        end
      end
      S_ROUND_R: begin
        cmd.round_r  = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt    = S_ALLOC_SCAN;
      end
      S_ALLOC_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = S_APPEND;
        end else if (sts.fit) begin
          cmd.reuse_wr   = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_sel    = ffha_pkg::RES_START;
          cmd.res_status = ffha_pkg::ST_DONE;
          state_nxt      = S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_APPEND: begin
        cmd.res_set = 1'b1;
        if (sts.nomem) begin
          cmd.res_status = ffha_pkg::ST_NOMEM;
        end else begin
          cmd.append     = 1'b1;
          cmd.res_sel    = ffha_pkg::RES_TOP;
          cmd.res_status = ffha_pkg::ST_DONE;
        end
        state_nxt = S_EMIT;
      end
      S_FREE_SCAN: begin
        if (sts.scan_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ffha_pkg::ST_UNKNOWN;
          state_nxt      = S_EMIT;
        end else if (sts.addr_hit) begin
          cmd.release_wr = 1'b1;
          cmd.scan_step  = 1'b1;
          state_nxt      = S_TAIL_SCAN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_TAIL_SCAN: begin
        if (sts.scan_end) begin
          cmd.cut        = 1'b1;
          cmd.res_set    = 1'b1;
          cmd.res_status = ffha_pkg::ST_DONE;
          state_nxt      = S_EMIT;
        end else if (!sts.blk_free) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ffha_pkg::ST_DONE;
          state_nxt      = S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/ffha_dp.sv
module ffha_dp #(
  parameter int unsigned GRANULE_BYTES = ffha_pkg::GRANULE_BYTES_DEF,
  parameter int unsigned HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS    = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HEAP_BYTES    = ffha_pkg::HEAP_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [31:0]                     in_tdata,
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ffha_pkg::ADDR_W-1:0]     out_tdata,
  output logic [ffha_pkg::STATUS_W-1:0]   out_tuser,
  input  ffha_pkg::dp_cmd_t               cmd,
  output ffha_pkg::dp_sts_t               sts
);

  localparam int AW   = $clog2(MAX_BLOCKS);
  localparam int CntW = $clog2(MAX_BLOCKS + 1);
  localparam int TopW = $clog2(HEAP_BYTES + 1);
  localparam int SumW = ((TopW > ffha_pkg::RSIZE_W) ? TopW : ffha_pkg::RSIZE_W) + 2;
  localparam int RW   = ffha_pkg::RSIZE_W;
  localparam int SW   = ffha_pkg::SIZE_W;
  localparam int QPW  = RW + ffha_pkg::RECIP_SHIFT + 1;
  localparam int RPW  = RW + 13;
  localparam longint unsigned RecipM =
    ((64'd1 << ffha_pkg::RECIP_SHIFT) + GRANULE_BYTES - 1) / GRANULE_BYTES;

  // memory word: free flag above payload size
  logic [SW:0] mem [MAX_BLOCKS];
  logic [SW:0] rdata_r;

  ffha_pkg::op_t     op_r;
  logic [SW-1:0]     size_r;
  logic [SW-1:0]     addr_r;
  logic [RW-1:0]     q_r;
  logic [RW-1:0]     rsize_r;
  logic [CntW-1:0]   idx_r;
  logic [CntW-1:0]   idx_nxt;
  logic [TopW-1:0]   start_r;
  logic [TopW-1:0]   start_nxt;
  logic [CntW-1:0]   count_r;
  logic [TopW-1:0]   top_r;
  logic [CntW-1:0]   cut_idx_r;
  logic [TopW-1:0]   cut_start_r;
  logic [ffha_pkg::ADDR_W-1:0] res_addr_r;
  ffha_pkg::status_t res_status_r;
  logic              out_valid_r;
  logic [ffha_pkg::ADDR_W-1:0] out_addr_r;
  ffha_pkg::status_t out_status_r;

  logic [RW-1:0]     size_up;
  logic [QPW-1:0]    qprod;
  logic [RPW-1:0]    rprod;
  logic [SumW-1:0]   start_h;
  logic [SumW-1:0]   top_h;
  logic [SumW-1:0]   top_end;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [SW:0]       wdata;
  logic              we;
  logic [ffha_pkg::ADDR_W-1:0] res_addr_nxt;

  assign size_up = {1'b0, size_r} + RW'(GRANULE_BYTES - 1);
  assign qprod   = QPW'(size_up) * QPW'(RecipM);
  assign rprod   = RPW'(q_r) * RPW'(GRANULE_BYTES);

  assign start_h = SumW'(start_r) + SumW'(HEADER_BYTES);
  assign top_h   = SumW'(top_r) + SumW'(HEADER_BYTES);
  assign top_end = top_h + SumW'(rsize_r);

  always_comb begin
    if (cmd.scan_clr) begin
      idx_nxt   = '0;
      start_nxt = '0;
    end else if (cmd.scan_step) begin
      idx_nxt   = idx_r + CntW'(1);
      start_nxt = TopW'(start_h + SumW'(rdata_r[SW-1:0]));
    end else begin
      idx_nxt   = idx_r;
      start_nxt = start_r;
    end
  end

  assign raddr = (idx_nxt < CntW'(MAX_BLOCKS)) ? idx_nxt[AW-1:0] : '0;
  assign we    = cmd.reuse_wr | cmd.release_wr | cmd.append;
  assign waddr = cmd.append ? count_r[AW-1:0] : idx_r[AW-1:0];
  assign wdata = cmd.append ? {1'b0, rsize_r[SW-1:0]} : {cmd.release_wr, rdata_r[SW-1:0]};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    case (cmd.res_sel)
      ffha_pkg::RES_START: res_addr_nxt = start_h[ffha_pkg::ADDR_W-1:0];
      ffha_pkg::RES_TOP:   res_addr_nxt = top_h[ffha_pkg::ADDR_W-1:0];
      default:             res_addr_nxt = '0;
    endcase
  end

  // request fields, scan position and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= ffha_pkg::op_t'(in_tuser);
      size_r <= in_tdata[SW-1:0];
      addr_r <= in_tdata[31:16];
    end
    if (cmd.round_q) begin
      q_r <= qprod[ffha_pkg::RECIP_SHIFT +: RW];
    end
    if (cmd.round_r) begin
      rsize_r <= rprod[RW-1:0];
    end
    idx_r   <= idx_nxt;
    start_r <= start_nxt;
    if (cmd.release_wr) begin
      cut_idx_r   <= idx_r;
      cut_start_r <= start_r;
    end
    if (cmd.res_set) begin
      res_addr_r   <= res_addr_nxt;
      res_status_r <= cmd.res_status;
    end
    if (cmd.emit) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.append) begin
        count_r <= count_r + CntW'(1);
        top_r   <= TopW'(top_end);
      end else if (cmd.cut) begin
        count_r <= cut_idx_r;
        top_r   <= cut_start_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.size_zero  = (size_r == '0);
    sts.addr_null  = (addr_r == '0);
    sts.count_zero = (count_r == '0);
    sts.scan_end   = (idx_r == count_r);
    sts.blk_free   = rdata_r[SW];
    sts.fit        = rdata_r[SW] && ({1'b0, rdata_r[SW-1:0]} >= rsize_r);
    sts.addr_hit   = (start_h == SumW'(addr_r));
    sts.nomem      = (count_r >= CntW'(MAX_BLOCKS)) ||
                     (rsize_r > RW'(17'h0FFFF)) ||
                     (top_end > SumW'(HEAP_BYTES)) ||
                     (top_h > SumW'(17'h0FFFF));
    sts.out_free   = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

endmodule

FILE: hdl/first_fit_heap_allocator_top.sv
// channel   dir  handshake            tdata                                    tuser
// in        in   in_tvalid/in_tready  [15:0] request_size [31:16] release_addr [0] cmd
// out       out  out_tvalid/out_tready [15:0] payload_address                  [1:0] status
//
// one request at a time; alloc and free are each a walk over the block table,
// one memory read per block
// rst_n synchronous active low clears block count, heap top and the result slot
// a result waits in the output register; the next request is taken meanwhile
module first_fit_heap_allocator_top #(
  parameter int unsigned GRANULE_BYTES = ffha_pkg::GRANULE_BYTES_DEF,
  parameter int unsigned HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS    = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HEAP_BYTES    = ffha_pkg::HEAP_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,   // request_size, release_address
  input  logic                          in_tuser,   // cmd
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ffha_pkg::ADDR_W-1:0]   out_tdata,  // payload_address
  output logic [ffha_pkg::STATUS_W-1:0] out_tuser   // status
);

  ffha_pkg::dp_cmd_t cmd;
  ffha_pkg::dp_sts_t sts;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffha_dp #(
    .GRANULE_BYTES (GRANULE_BYTES),
    .HEADER_BYTES  (HEADER_BYTES),
    .MAX_BLOCKS    (MAX_BLOCKS),
    .HEAP_BYTES    (HEAP_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in progress");

  a_null_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ffha_pkg::ST_DONE) |-> (out_tdata == '0))
    else $error("nonzero address with failing status");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a request in progress");

endmodule
